// ----- rtl/wis_pkg.sv -----
// Shared types, constants and table lookup functions for the watchdog interval selector.
package wis_pkg;

	localparam int TBL_LEN   = 8;
	localparam int TICK_W    = 48;
	localparam int HALF_W    = TICK_W / 2;
	localparam int MUL_A_W   = 32;
	localparam int MUL_B_W   = 26;
	localparam int MUL_W     = MUL_A_W + MUL_B_W;
	localparam int PART_W    = HALF_W + MUL_B_W;
	localparam int PROD_W    = TICK_W + MUL_B_W;
	localparam int DIVD_W    = 60;
	localparam int DIV_BITS  = 4;
	localparam int DIV_STEPS = DIVD_W / DIV_BITS;
	localparam int DCNT_W    = $clog2(DIV_STEPS);
	localparam int REM_W     = 11;
	localparam int K_W       = 16;
	localparam int CFG_W     = 26;
	localparam int VLO_W     = 17;

	localparam logic [REM_W-1:0] DIV_K = REM_W'(1000);
	localparam logic [2:0] CODE_MAX = 3'(TBL_LEN - 1);

	// register indexes on the config port
	localparam logic [1:0] REG_SMCLK = 2'd0;
	localparam logic [1:0] REG_ACLK  = 2'd1;
	localparam logic [1:0] REG_VLO   = 2'd2;

	// clock source codes
	localparam logic [1:0] SRC_SMCLK = 2'd0;
	localparam logic [1:0] SRC_ACLK  = 2'd1;
	localparam logic [1:0] SRC_VLO   = 2'd2;

	localparam logic [31:0] INTERVAL_TICKS [TBL_LEN] = '{
		32'd2000000000, 32'd128000000, 32'd8192000, 32'd512000,
		32'd32768, 32'd8192, 32'd512, 32'd64
	};

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	typedef struct packed {
		logic [2:0]        code;
		logic [TICK_W-1:0] err;
	} pick_t;

	// highest code whose entry is not below the tick count, else code 0
	function automatic logic [2:0] near_code(input logic [TICK_W-1:0] ticks);
		logic [2:0] d;
		d = '0;
		for (int i = 0; i < TBL_LEN; i++) begin
			if (ticks <= TICK_W'(INTERVAL_TICKS[i])) begin
				d = 3'(i);
			end
		end
		return d;
	endfunction

	// nearer of the two neighbouring entries; the longer one wins a tie
	function automatic pick_t near_pick(input logic [TICK_W-1:0] ticks, input logic [2:0] d);
		logic [TICK_W-1:0] hi_e;
		logic [TICK_W-1:0] lo_e;
		logic [TICK_W-1:0] up;
		logic [TICK_W-1:0] dn;
		pick_t p;
		hi_e = TICK_W'(INTERVAL_TICKS[d]);
		if (d == CODE_MAX || d == 3'd0) begin
			p.code = d;
			p.err = (hi_e >= ticks) ? (hi_e - ticks) : (ticks - hi_e);
		end else begin
			lo_e = TICK_W'(INTERVAL_TICKS[d + 3'd1]);
			up = hi_e - ticks;
			dn = ticks - lo_e;
			if (up > dn) begin
				p.code = d + 3'd1;
				p.err = dn;
			end else begin
				p.code = d;
				p.err = up;
			end
		end
		return p;
	endfunction

endpackage

// ----- rtl/wis_mul.sv -----
// Shared registered multiplier, 32 by 26 bits.
module wis_mul
	import wis_pkg::*;
(
	input  logic               clk,
	input  logic [MUL_A_W-1:0] a,
	input  logic [MUL_B_W-1:0] b,
	output logic [MUL_W-1:0]   prod_s1
);

	always_ff @(posedge clk) begin
		prod_s1 <= MUL_W'(a) * MUL_W'(b);
	end

endmodule

// ----- rtl/wis_div.sv -----
// Iterative divide by 1000, four quotient bits per cycle.
module wis_div
	import wis_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIVD_W-1:0] dividend,
	output logic [DIVD_W-1:0] quotient,
	output div_stat_t         stat
);

	logic [DIVD_W-1:0] dq_q;
	logic [REM_W-1:0]  rem_q;
	logic [DCNT_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIVD_W-1:0] dq_nx;
	logic [REM_W-1:0]  rem_nx;

	// restoring steps; remainder stays below 1000 between steps
	always_comb begin
		dq_nx = dq_q;
		rem_nx = rem_q;
		for (int i = 0; i < DIV_BITS; i++) begin
			rem_nx = {rem_nx[REM_W-2:0], dq_nx[DIVD_W-1]};
			dq_nx = {dq_nx[DIVD_W-2:0], 1'b0};
			if (rem_nx >= DIV_K) begin
				rem_nx = rem_nx - DIV_K;
				dq_nx[0] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				if (cnt_q == DCNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + DCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dq_q <= dq_nx;
			rem_q <= rem_nx;
		end
	end

	assign quotient = dq_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ----- rtl/watchdog_interval_select.sv -----
// Top level of the watchdog interval selector: sequencer, operand routing and result register.
//
//  channel | signals                           | direction | payload
//  --------+-----------------------------------+-----------+--------------------------------
//  req     | req_valid / req_stall             | in        | timeout_ms[31:0]
//  rsp     | rsp_valid / rsp_stall             | out       | clock_source[1:0], interval_index[2:0]
//  cfg     | cfg_valid / cfg_ready (always 1)  | in        | cfg_index[1:0], cfg_data[25:0]
//
// Each item takes the same time whatever its value. Most of it is three passes of the
// divide-by-1000 unit (4 quotient bits a cycle) and twelve partial products through the
// single 32x26 multiplier (each an issue state, then an accumulate state).
// req_stall is high from acceptance until the result is loaded into the output register;
// a result waiting on rsp_stall holds the sequencer in its last state until it drains.
// Reset loads the clock registers with 1 MHz, 32768 Hz and 10 kHz and empties the pipe.
module watchdog_interval_select
	import wis_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  logic [31:0]      timeout_ms,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output logic [1:0]       clock_source,
	output logic [2:0]       interval_index,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	typedef enum logic [10:0] {
		S_IDLE  = 11'b000_0000_0001,
		S_DIVK  = 11'b000_0000_0010,
		S_MUL   = 11'b000_0000_0100,
		S_MULW  = 11'b000_0000_1000,
		S_DIV   = 11'b000_0001_0000,
		S_PICK1 = 11'b000_0010_0000,
		S_PICK2 = 11'b000_0100_0000,
		S_PMUL  = 11'b000_1000_0000,
		S_PACC  = 11'b001_0000_0000,
		S_CMP   = 11'b010_0000_0000,
		S_OUT   = 11'b100_0000_0000
	} state_t;

	state_t state_q;

	// clock frequency registers
	logic [CFG_W-1:0] smclk_q;
	logic [CFG_W-1:0] aclk_q;
	logic [VLO_W-1:0] vlo_q;

	// working registers
	logic [31:0]       ms_q;
	logic [K_W-1:0]    k_q;
	logic [TICK_W-1:0] ticks_q;
	logic [2:0]        dpre_q;
	logic [TICK_W-1:0] err_s_q, err_a_q, err_v_q;
	logic [2:0]        code_s_q, code_a_q, code_v_q;
	logic [1:0]        src_q;
	logic [1:0]        pair_q;
	logic [1:0]        part_q;
	logic [PROD_W-1:0] acc_q;
	logic [PROD_W-1:0] pa_q;
	logic [2:0]        le_xy_q;
	logic              le_as_q;

	logic              rsp_valid_q;
	logic [1:0]        clock_source_q;
	logic [2:0]        interval_index_q;

	// shared units
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [MUL_W-1:0]   mul_p;
	logic               div_start;
	logic [DIVD_W-1:0]  div_dvd;
	logic [DIVD_W-1:0]  div_quo;
	div_stat_t          div_stat;

	logic               req_take;
	logic               out_load;
	logic [CFG_W-1:0]   fs, fa, fv;
	logic [CFG_W-1:0]   fx, fy;
	logic [TICK_W-1:0]  ex, ey, e_op;
	logic [HALF_W-1:0]  e_half;
	logic [PROD_W-1:0]  acc_nx;
	logic               le_xy, le_yx;
	pick_t              pick;
	logic [1:0]         sel_src;
	logic [2:0]         sel_code;

	wis_mul u_mul (
		.clk     (clk),
		.a       (mul_a),
		.b       (mul_b),
		.prod_s1 (mul_p)
	);

	wis_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.quotient (div_quo),
		.stat     (div_stat)
	);

	assign req_stall = (state_q != S_IDLE);
	assign req_take = req_valid && !req_stall;
	assign cfg_ready = 1'b1;
	assign out_load = (state_q == S_OUT) && (!rsp_valid_q || !rsp_stall);

	assign fs = smclk_q;
	assign fa = aclk_q;
	assign fv = CFG_W'(vlo_q);

	// pair 0: SMCLK vs ACLK, pair 1: SMCLK vs VLO, pair 2: ACLK vs VLO
	always_comb begin
		case (pair_q)
			2'd0: begin
				ex = err_s_q; fx = fs; ey = err_a_q; fy = fa;
			end
			2'd1: begin
				ex = err_s_q; fx = fs; ey = err_v_q; fy = fv;
			end
			default: begin
				ex = err_a_q; fx = fa; ey = err_v_q; fy = fv;
			end
		endcase
	end

	// parts 0,1: err_x * f_y (low then high half); parts 2,3: err_y * f_x
	assign e_op = part_q[1] ? ey : ex;
	assign e_half = part_q[0] ? e_op[TICK_W-1:HALF_W] : e_op[HALF_W-1:0];

	always_comb begin
		if (state_q == S_PMUL) begin
			mul_a = MUL_A_W'(e_half);
			mul_b = part_q[1] ? fx : fy;
		end else begin
			mul_a = ms_q;
			case (src_q)
				SRC_SMCLK: mul_b = MUL_B_W'(k_q);
				SRC_ACLK:  mul_b = fa;
				default:   mul_b = fv;
			endcase
		end
	end

	assign div_start = req_take || (state_q == S_MULW && src_q != SRC_SMCLK);
	assign div_dvd = (state_q == S_IDLE) ? DIVD_W'(smclk_q) : DIVD_W'(mul_p);

	// high half lands 24 bits up on top of the low half
	assign acc_nx = part_q[0]
		? acc_q + {mul_p[PART_W-1:0], {HALF_W{1'b0}}}
		: PROD_W'(mul_p[PART_W-1:0]);

	// a zero frequency counts as infinite error
	assign le_xy = (fy == '0) || ((fx != '0) && (pa_q <= acc_q));
	assign le_yx = (fx == '0) || ((fy != '0) && (acc_q <= pa_q));

	assign pick = near_pick(ticks_q, dpre_q);

	always_comb begin
		if (le_xy_q[0] && le_xy_q[1]) begin
			sel_src = SRC_SMCLK;
			sel_code = code_s_q;
		end else if (le_as_q && le_xy_q[2]) begin
			sel_src = SRC_ACLK;
			sel_code = code_a_q;
		end else begin
			sel_src = SRC_VLO;
			sel_code = code_v_q;
		end
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smclk_q <= CFG_W'(1000000);
			aclk_q <= CFG_W'(32768);
			vlo_q <= VLO_W'(10000);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SMCLK: smclk_q <= cfg_data;
				REG_ACLK:  aclk_q <= cfg_data;
				REG_VLO:   vlo_q <= cfg_data[VLO_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			src_q <= SRC_SMCLK;
			pair_q <= '0;
			part_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_take) begin
						src_q <= SRC_SMCLK;
						state_q <= S_DIVK;
					end
				end
				S_DIVK: begin
					if (div_stat.done) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: state_q <= S_MULW;
				S_MULW: state_q <= (src_q == SRC_SMCLK) ? S_PICK1 : S_DIV;
				S_DIV: begin
					if (div_stat.done) begin
						state_q <= S_PICK1;
					end
				end
				S_PICK1: state_q <= S_PICK2;
				S_PICK2: begin
					if (src_q == SRC_VLO) begin
						pair_q <= '0;
						part_q <= '0;
						state_q <= S_PMUL;
					end else begin
						src_q <= src_q + 2'd1;
						state_q <= S_MUL;
					end
				end
				S_PMUL: state_q <= S_PACC;
				S_PACC: begin
					part_q <= part_q + 2'd1;
					state_q <= (part_q == 2'd3) ? S_CMP : S_PMUL;
				end
				S_CMP: begin
					part_q <= '0;
					if (pair_q == 2'd2) begin
						state_q <= S_OUT;
					end else begin
						pair_q <= pair_q + 2'd1;
						state_q <= S_PMUL;
					end
				end
				S_OUT: begin
					if (out_load) begin
						rsp_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req_take) begin
			ms_q <= timeout_ms;
		end
		if (state_q == S_DIVK && div_stat.done) begin
			k_q <= div_quo[K_W-1:0];
		end
		if (state_q == S_MULW && src_q == SRC_SMCLK) begin
			ticks_q <= mul_p[TICK_W-1:0];
		end
		if (state_q == S_DIV && div_stat.done) begin
			ticks_q <= div_quo[TICK_W-1:0];
		end
		if (state_q == S_PICK1) begin
			dpre_q <= near_code(ticks_q);
		end
		if (state_q == S_PICK2) begin
			case (src_q)
				SRC_SMCLK: begin
					err_s_q <= pick.err;
					code_s_q <= pick.code;
				end
				SRC_ACLK: begin
					err_a_q <= pick.err;
					code_a_q <= pick.code;
				end
				default: begin
					err_v_q <= pick.err;
					code_v_q <= pick.code;
				end
			endcase
		end
		if (state_q == S_PACC) begin
			acc_q <= acc_nx;
			if (part_q == 2'd1) begin
				pa_q <= acc_nx;
			end
		end
		if (state_q == S_CMP) begin
			le_xy_q[pair_q] <= le_xy;
			if (pair_q == 2'd0) begin
				le_as_q <= le_yx;
			end
		end
		if (out_load) begin
			clock_source_q <= sel_src;
			interval_index_q <= sel_code;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign clock_source = clock_source_q;
	assign interval_index = interval_index_q;

	a_div_done_owned: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == S_DIVK || state_q == S_DIV))
		else $error("divider finished outside a divide state");

	a_prod_after_picks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PMUL || state_q == S_PACC || state_q == S_CMP) |-> (src_q == SRC_VLO))
		else $error("error products started before all three sources were picked");

	a_take_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req_take |-> !div_stat.busy)
		else $error("item taken while divider busy");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (rsp_valid && state_q == S_IDLE))
		else $error("loaded result not presented");

	a_pair_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP) |-> (pair_q != 2'd3 && part_q == 2'd0))
		else $error("compare on bad pair or partial product count");

endmodule

// ----- test/tb_watchdog_interval_select.sv -----
// Self-checking testbench for the watchdog interval selector: directed table, random timeouts and clock settings.
`timescale 1ns / 1ps

module tb_watchdog_interval_select;
	import wis_pkg::*;

	localparam int CLK_HALF     = 5;
	localparam int RESET_CYCLES = 8;
	localparam int RAND_PHASES  = 10;
	localparam int PHASE_ITEMS  = 123;
	localparam int DRAIN_CYCLES = 120;         // a bit over one item's worth of sequencer cycles
	localparam int CYCLE_LIMIT  = 1_000_000;   // the slowest legal run stays well under this
	localparam logic [1:0] REG_UNUSED = 2'd3;  // no register sits behind this index

	// chosen source and interval code, laid out as on the result port
	typedef struct packed {
		logic [1:0] src;
		logic [2:0] code;
	} choice_t;

	// nearest table entry for one clock and its absolute tick error
	typedef struct packed {
		logic [2:0]  code;
		logic [63:0] err;
	} fit_t;

	typedef enum logic [1:0] { ROW_CFG, ROW_ITEM, ROW_KNOWN } row_kind_e;

	// one line of the directed table
	typedef struct packed {
		row_kind_e   kind;
		logic [1:0]  reg_idx;
		logic [31:0] value;
		choice_t     known;
	} step_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             req_valid = 1'b0;
	logic             req_stall;
	logic [31:0]      timeout_ms = '0;
	logic             rsp_valid;
	logic             rsp_stall = 1'b0;
	logic [1:0]       clock_source;
	logic [2:0]       interval_index;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [1:0]       cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	// our own copy of the clock registers, starting from their reset values
	logic [CFG_W-1:0] smclk_hz = 26'd1000000;
	logic [CFG_W-1:0] aclk_hz  = 26'd32768;
	logic [VLO_W-1:0] vlo_hz   = 17'd10000;

	choice_t pending_choices [$];
	step_t   plan [$];
	int      mismatch_count = 0;
	int      cycle_count = 0;
	int      send_idle_pct = 7;
	int      recv_stall_pct = 46;

	watchdog_interval_select u_dut (.*);

	always #CLK_HALF clk = ~clk;

	// ---------------------------------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------------------------------

	// watchdog interval table, code 0 longest
	function automatic logic [63:0] period_ticks(input int code);
		case (code)
			0: return 64'd2000000000;
			1: return 64'd128000000;
			2: return 64'd8192000;
			3: return 64'd512000;
			4: return 64'd32768;
			5: return 64'd8192;
			6: return 64'd512;
			default: return 64'd64;
		endcase
	endfunction

	// walk up from the shortest entry; between two entries the shorter one must be
	// strictly nearer, otherwise the longer one is kept; both ends clamp
	function automatic fit_t nearest_period(input logic [63:0] ticks);
		fit_t        f;
		int          d;
		logic [63:0] up;
		logic [63:0] dn;
		d = 7;
		while (ticks > period_ticks(d) && d > 0)
			d--;
		if (d == 7 || d == 0) begin
			f.code = 3'(d);
			f.err  = (period_ticks(d) >= ticks) ? period_ticks(d) - ticks : ticks - period_ticks(d);
		end else begin
			up = period_ticks(d) - ticks;
			dn = ticks - period_ticks(d + 1);
			if (up > dn) begin
				f.code = 3'(d + 1);
				f.err  = dn;
			end else begin
				f.code = 3'(d);
				f.err  = up;
			end
		end
		return f;
	endfunction

	// ea/fa <= eb/fb, cross-multiplied; a stopped clock has unbounded error
	function automatic bit time_err_le(input logic [63:0] ea, input logic [CFG_W-1:0] fa,
			input logic [63:0] eb, input logic [CFG_W-1:0] fb);
		logic [127:0] lhs;
		logic [127:0] rhs;
		if (fb == '0)
			return 1'b1;
		if (fa == '0)
			return 1'b0;
		lhs = 128'(ea) * 128'(fb);
		rhs = 128'(eb) * 128'(fa);
		return lhs <= rhs;
	endfunction

	function automatic choice_t choose_interval(input logic [31:0] ms);
		fit_t             fs;
		fit_t             fa;
		fit_t             fv;
		logic [CFG_W-1:0] vhz;
		vhz = CFG_W'(vlo_hz);
		// SMCLK is scaled per millisecond first, so it truncates before the multiply
		fs = nearest_period(64'(ms) * 64'(smclk_hz / 26'd1000));
		fa = nearest_period(64'(ms) * 64'(aclk_hz) / 64'd1000);
		fv = nearest_period(64'(ms) * 64'(vlo_hz) / 64'd1000);
		if (time_err_le(fs.err, smclk_hz, fa.err, aclk_hz) &&
				time_err_le(fs.err, smclk_hz, fv.err, vhz))
			return {SRC_SMCLK, fs.code};
		if (time_err_le(fa.err, aclk_hz, fs.err, smclk_hz) &&
				time_err_le(fa.err, aclk_hz, fv.err, vhz))
			return {SRC_ACLK, fa.code};
		return {SRC_VLO, fv.code};
	endfunction

	// ---------------------------------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------------------------------

	function automatic step_t cfg_row(input logic [1:0] idx, input logic [31:0] data);
		step_t s;
		s = '0;
		s.kind    = ROW_CFG;
		s.reg_idx = idx;
		s.value   = data;
		return s;
	endfunction

	function automatic step_t item_row(input logic [31:0] ms);
		step_t s;
		s = '0;
		s.kind  = ROW_ITEM;
		s.value = ms;
		return s;
	endfunction

	function automatic step_t known_row(input logic [31:0] ms, input logic [1:0] src,
			input logic [2:0] code);
		step_t s;
		s = '0;
		s.kind  = ROW_KNOWN;
		s.value = ms;
		s.known = {src, code};
		return s;
	endfunction

	// mostly in-range rates, with the range ends, a stopped clock, sub-kHz values and
	// full-width data (VLO keeps only its low 17 bits) mixed in
	function automatic logic [CFG_W-1:0] random_rate(input logic [1:0] idx);
		logic [CFG_W-1:0] lo;
		logic [CFG_W-1:0] hi;
		case (idx)
			REG_SMCLK: begin
				lo = 26'd1000;
				hi = 26'd50000000;
			end
			REG_ACLK: begin
				lo = 26'd1;
				hi = 26'd50000000;
			end
			default: begin
				lo = 26'd1;
				hi = 26'd100000;
			end
		endcase
		case ($urandom_range(0, 11))
			0: return lo;
			1: return hi;
			2: return '0;
			3: return CFG_W'($urandom);
			4: return CFG_W'($urandom_range(999, 1));
			default: return CFG_W'($urandom_range(hi, lo));
		endcase
	endfunction

	// a good share of timeouts is aimed at table entries and at midpoints between
	// neighbouring entries for one of the current clocks, where the rounding decides
	function automatic logic [31:0] random_timeout();
		logic [63:0] t;
		logic [63:0] ms;
		logic [63:0] per;
		int          k;
		int          which;
		case ($urandom_range(0, 7))
			0: return $urandom;
			1: return $urandom >> $urandom_range(31, 0);
			2: return $urandom_range(2000, 0);
			3: return ($urandom_range(1, 0) != 0) ? 32'hFFFF_FFFF : 32'd0;
			4, 5: begin
				k = $urandom_range(7, 0);
				t = (k < 7 && $urandom_range(1, 0) != 0) ?
					(period_ticks(k) + period_ticks(k + 1)) / 2 : period_ticks(k);
				which = $urandom_range(2, 0);
				if (which == 0) begin
					per = 64'(smclk_hz / 26'd1000);
					if (per == 0)
						return $urandom;
					ms = t / per;
				end else begin
					per = (which == 1) ? 64'(aclk_hz) : 64'(vlo_hz);
					if (per == 0)
						return $urandom;
					ms = t * 64'd1000 / per;
				end
				ms = ms + 64'($urandom_range(4, 0));
				if (ms >= 2)
					ms = ms - 2;
				return (ms > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : ms[31:0];
			end
			default: return $urandom_range(10_000_000, 0);
		endcase
	endfunction

	// offer one timeout, hold it until accepted, then book its expected choice
	task automatic send_timeout(input logic [31:0] ms, input choice_t want);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid  <= 1'b1;
		timeout_ms <= ms;
		do
			@(posedge clk);
		while (req_stall);
		pending_choices.push_back(want);
	endtask

	// hold the request side off until every outstanding result has drained
	task automatic wait_drained();
		req_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_choices.size() != 0);
	endtask

	// one register write; the shadow copy follows once the write has gone through
	task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			REG_SMCLK: smclk_hz = data;
			REG_ACLK:  aclk_hz  = data;
			REG_VLO:   vlo_hz   = data[VLO_W-1:0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// ---------------------------------------------------------------------------------------
	// Result side: random back-pressure and in-order check against the expected choices
	// ---------------------------------------------------------------------------------------
	always @(posedge clk) begin : rsp_check
		choice_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_choices.size() == 0) begin
				$error("unexpected result: clock_source %0d interval_index %0d",
					clock_source, interval_index);
				mismatch_count++;
			end else begin
				want = pending_choices.pop_front();
				if (clock_source !== want.src) begin
					$error("clock_source: expected %0d, got %0d", want.src, clock_source);
					mismatch_count++;
				end
				if (interval_index !== want.code) begin
					$error("interval_index: expected %0d, got %0d", want.code, interval_index);
					mismatch_count++;
				end
			end
		end
		rsp_stall <= ($urandom_range(99, 0) < recv_stall_pct);
	end

	// watchdog on the testbench itself
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// ---------------------------------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------------------------------
	initial begin : stimulus
		step_t       row;
		logic [31:0] ms;

		// reset clock settings: 1 MHz, 32768 Hz, 10 kHz
		plan.push_back(known_row(32'd0, SRC_SMCLK, 3'd7));          // zero ticks everywhere
		plan.push_back(known_row(32'hFFFF_FFFF, SRC_VLO, 3'd0));    // all clamp at the top
		plan.push_back(item_row(32'd1));
		plan.push_back(known_row(32'd512, SRC_SMCLK, 3'd3));        // exact SMCLK hits
		plan.push_back(known_row(32'd8192, SRC_SMCLK, 3'd2));
		plan.push_back(known_row(32'd128000, SRC_SMCLK, 3'd1));
		plan.push_back(known_row(32'd2000000, SRC_SMCLK, 3'd0));
		plan.push_back(known_row(32'd1000, SRC_ACLK, 3'd4));        // exact ACLK hit
		plan.push_back(item_row(32'h8000_0000));
		plan.push_back(item_row(32'h5555_5555));
		plan.push_back(item_row(32'hAAAA_AAAA));
		// identical clocks: midway between two entries keeps the longer, SMCLK takes the tie
		plan.push_back(cfg_row(REG_SMCLK, 32'd1000));
		plan.push_back(cfg_row(REG_ACLK, 32'd1000));
		plan.push_back(cfg_row(REG_VLO, 32'd1000));
		plan.push_back(known_row(32'd288, SRC_SMCLK, 3'd6));
		plan.push_back(known_row(32'd2000000000, SRC_SMCLK, 3'd0));
		plan.push_back(item_row(32'hFFFF_FFFF));
		// SMCLK stopped: it loses, and ACLK takes its tie with VLO
		plan.push_back(cfg_row(REG_SMCLK, 32'd0));
		plan.push_back(known_row(32'd288, SRC_ACLK, 3'd6));
		// every clock stopped: the tie order alone picks SMCLK at zero ticks
		plan.push_back(cfg_row(REG_ACLK, 32'd0));
		plan.push_back(cfg_row(REG_VLO, 32'd0));
		plan.push_back(known_row(32'd5000, SRC_SMCLK, 3'd7));
		// SMCLK just under 1 kHz (no ticks per ms) against the fastest ACLK and VLO
		plan.push_back(cfg_row(REG_SMCLK, 32'd999));
		plan.push_back(cfg_row(REG_ACLK, 32'd50000000));
		plan.push_back(cfg_row(REG_VLO, 32'd100000));
		plan.push_back(item_row(32'd0));
		plan.push_back(item_row(32'd1));
		plan.push_back(item_row(32'd40));
		plan.push_back(item_row(32'hFFFF_FFFF));
		// fastest SMCLK, slowest ACLK and VLO
		plan.push_back(cfg_row(REG_SMCLK, 32'd50000000));
		plan.push_back(cfg_row(REG_ACLK, 32'd1));
		plan.push_back(cfg_row(REG_VLO, 32'd1));
		plan.push_back(item_row(32'hFFFF_FFFF));
		plan.push_back(item_row(32'd1));
		plan.push_back(item_row(32'd40));
		// a write to the spare index must leave every clock alone
		plan.push_back(cfg_row(REG_UNUSED, 32'h03FF_FFFF));
		plan.push_back(item_row(32'd7));
		// full-width data into VLO keeps only its low bits
		plan.push_back(cfg_row(REG_VLO, 32'h03FF_FFFF));
		plan.push_back(item_row(32'd100));

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			row = plan[i];
			case (row.kind)
				ROW_CFG: begin
					wait_drained();
					write_reg(row.reg_idx, CFG_W'(row.value));
				end
				ROW_KNOWN: send_timeout(row.value, row.known);
				default:   send_timeout(row.value, choose_interval(row.value));
			endcase
		end

		// random part: fresh clock settings per phase; the idling pattern flips after
		// four phases and is switched off for the last two
		for (int p = 0; p < RAND_PHASES; p++) begin
			wait_drained();
			if (p == 4) begin
				send_idle_pct  = 46;
				recv_stall_pct = 7;
			end else if (p == 8) begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end
			write_reg(REG_SMCLK, random_rate(REG_SMCLK));
			write_reg(REG_ACLK, random_rate(REG_ACLK));
			write_reg(REG_VLO, random_rate(REG_VLO));
			if ($urandom_range(3, 0) == 0)
				write_reg(REG_UNUSED, CFG_W'($urandom));
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// now and then let the pipe run empty before the next item
				if ($urandom_range(39, 0) == 0)
					wait_drained();
				ms = random_timeout();
				send_timeout(ms, choose_interval(ms));
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/wis_pkg.sv
rtl/wis_mul.sv
rtl/wis_div.sv
rtl/watchdog_interval_select.sv
test/tb_watchdog_interval_select.sv
